FILE: src/smd_pkg.sv
package smd_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int COUNT_W    = $clog2(ENTRIES + 1);
  localparam int COORD_BITS = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEY_W      = 2 * COORD_BITS;
  localparam int WORD_W     = KEY_W + VALUE_BITS;

  localparam logic [VALUE_BITS-1:0] DEFAULT_RESET = '1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  typedef struct packed {
    logic req_ready;
    logic scan_en;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: src/smd_if.sv
interface smd_req_if import smd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [COORD_BITS-1:0]        row;
  logic [COORD_BITS-1:0]        col;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface smd_rsp_if import smd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] cell_value;
  logic                         found;
  logic [COUNT_W-1:0]           entry_count;
  logic                         dropped;

  modport source (output valid, cell_value, found, entry_count, dropped, input ready);
  modport sink   (input valid, cell_value, found, entry_count, dropped, output ready);
endinterface

interface smd_cfg_if import smd_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/smd_ctrl.sv
module smd_ctrl import smd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.req_ready = (state == S_IDLE);
    cmd.scan_en   = (state == S_SCAN);
    cmd.exec      = (state == S_EXEC) && sts.out_free;
    case (state)
      S_IDLE: begin
        state_next = sts.req_valid ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        state_next = sts.scan_done ? S_EXEC : S_SCAN;
      end
      S_EXEC: begin
        state_next = sts.out_free ? S_IDLE : S_EXEC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/smd_dp.sv
module smd_dp import smd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  smd_req_if.sink   req,
  smd_rsp_if.source rsp,
  smd_cfg_if.sink   cfg,
  input  ctl_cmd_t  cmd,
  output dp_sts_t   sts
);

  // slot memory word: {key, data}
  logic [WORD_W-1:0]     mem [ENTRIES];
  logic [WORD_W-1:0]     rd_word;
  logic [ENTRIES-1:0]    slot_valid;
  logic [COUNT_W-1:0]    live_count;
  logic [VALUE_BITS-1:0] default_value;

  logic                  op_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [IDX_W-1:0]      scan_addr;
  logic                  issued_all;
  logic                  pend;
  logic [IDX_W-1:0]      pend_idx;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [VALUE_BITS-1:0] hit_data;
  logic                  free_seen;
  logic [IDX_W-1:0]      free_idx;

  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_cell;
  logic                  out_found;
  logic                  out_dropped;

  logic                  start;
  logic                  issue;
  logic                  match;
  logic                  is_erase;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [VALUE_BITS-1:0] res_cell;
  logic                  res_found;
  logic                  res_dropped;

  assign start     = req.valid && cmd.req_ready;
  assign issue     = cmd.scan_en && !issued_all;
  assign match     = pend && slot_valid[pend_idx] &&
                     (rd_word[WORD_W-1:VALUE_BITS] == key_q);
  assign req.ready = cmd.req_ready;
  assign cfg.ready = 1'b1;

  assign sts.req_valid = req.valid;
  assign sts.scan_done = cmd.scan_en && pend &&
                         (match || (pend_idx == IDX_W'(ENTRIES - 1)));
  assign sts.out_free  = !out_valid || rsp.ready;

  always_comb begin
    is_erase    = (op_q == OP_WRITE) && (val_q == default_value);
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    res_cell    = default_value;
    res_found   = 1'b0;
    res_dropped = 1'b0;
    if (op_q == OP_READ) begin
      if (hit) begin
        res_cell  = hit_data;
        res_found = 1'b1;
      end
    end else if (!is_erase) begin
      if (hit) begin
        wr_en     = 1'b1;
        res_cell  = val_q;
        res_found = 1'b1;
      end else if (free_seen) begin
        wr_en     = 1'b1;
        wr_idx    = free_idx;
        res_cell  = val_q;
        res_found = 1'b1;
      end else begin
        res_dropped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= mem[scan_addr];
    end
    if (cmd.exec && wr_en) begin
      mem[wr_idx] <= {key_q, val_q};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_q  <= req.op;
      key_q <= {req.row, req.col};
      val_q <= req.value;
    end
    if (match) begin
      hit_idx  <= pend_idx;
      hit_data <= rd_word[VALUE_BITS-1:0];
    end
    if (issue && !slot_valid[scan_addr] && !free_seen) begin
      free_idx <= scan_addr;
    end
    if (issue) begin
      pend_idx <= scan_addr;
    end
    if (cmd.exec) begin
      out_cell    <= res_cell;
      out_found   <= res_found;
      out_dropped <= res_dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr     <= '0;
      issued_all    <= 1'b0;
      pend          <= 1'b0;
      hit           <= 1'b0;
      free_seen     <= 1'b0;
      slot_valid    <= '0;
      live_count    <= '0;
      default_value <= DEFAULT_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        default_value <= cfg.data;
      end
      if (start) begin
        scan_addr  <= '0;
        issued_all <= 1'b0;
        pend       <= 1'b0;
        hit        <= 1'b0;
        free_seen  <= 1'b0;
      end else if (cmd.scan_en) begin
        pend <= issue;
        if (match) begin
          hit <= 1'b1;
        end
        if (issue) begin
          if (!slot_valid[scan_addr]) begin
            free_seen <= 1'b1;
          end
          if (scan_addr == IDX_W'(ENTRIES - 1)) begin
            issued_all <= 1'b1;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
      end
      if (cmd.exec) begin
        if (is_erase && hit) begin
          slot_valid[hit_idx] <= 1'b0;
          live_count          <= live_count - 1'b1;
        end else if (wr_en && !hit) begin
          slot_valid[free_idx] <= 1'b1;
          live_count           <= live_count + 1'b1;
        end
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.cell_value  = out_cell;
  assign rsp.found       = out_found;
  assign rsp.entry_count = live_count;
  assign rsp.dropped     = out_dropped;

endmodule

FILE: src/sparse_matrix_default_store.sv
// Sparse matrix store: up to 64 (row, col) cells, keyed by row above col.
// A read returns the held value or the default; writing the default erases
// the cell, writing anything else updates it or takes the lowest free slot,
// and a write to a full table is dropped and flagged. Each accepted item
// returns one result carrying the live entry count. Items are handled one at
// a time: the key/data memory is walked one slot per cycle through a single
// read port, stopping at the hit or after the last slot. The default value
// is written on the cfg channel; the user must do so only while no item is
// in flight, as the block itself does not enforce this. It resets to -1.
// Slot valid bits are flops cleared at reset, so no clearing pass is needed.
// A pending result does not block the next accept.
module sparse_matrix_default_store import smd_pkg::*; (
  input logic       clk,
  input logic       rst,
  smd_req_if.sink   req,
  smd_rsp_if.source rsp,
  smd_cfg_if.sink   cfg
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  smd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  smd_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

FILE: src/smd_chk.sv
module smd_chk import smd_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic signed [VALUE_BITS-1:0] rsp_cell_value,
  input logic                         rsp_found,
  input logic [COUNT_W-1:0]           rsp_entry_count,
  input logic                         rsp_dropped
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) &&
                                $stable(rsp_found) && $stable(rsp_dropped))
    else $error("result changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_entry_count <= COUNT_W'(ENTRIES))
    else $error("entry count above capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_dropped |->
      !rsp_found && (rsp_entry_count == COUNT_W'(ENTRIES)))
    else $error("drop reported with room left or cell found");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a transfer while busy");

endmodule

bind sparse_matrix_default_store smd_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_cell_value  (rsp.cell_value),
  .rsp_found       (rsp.found),
  .rsp_entry_count (rsp.entry_count),
  .rsp_dropped     (rsp.dropped)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL        = 128;

  typedef logic signed [VALUE_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct {
    word_t              cell_value;
    logic               found;
    logic [COUNT_W-1:0] entry_count;
    logic               dropped;
  } reply_t;

  class cell_tracker;
    bit               used[ENTRIES];
    logic [KEY_W-1:0] key[ENTRIES];
    word_t            data[ENTRIES];
    int               live;
    word_t            dflt;
    reply_t           due[$];
    int               errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      live   = 0;
      dflt   = DEFAULT_RESET;
      errors = 0;
    endfunction

    function void set_default(word_t v);
      dflt = v;
    endfunction

    function word_t held_value();
      foreach (used[i]) if (used[i]) return data[i];
      return $urandom;
    endfunction

    function void note_access(logic op, logic [COORD_BITS-1:0] row,
                              logic [COORD_BITS-1:0] col, word_t value);
      logic [KEY_W-1:0] k;
      int               hit;
      int               spare;
      reply_t           r;
      k     = {row, col};
      hit   = -1;
      spare = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (used[i] && key[i] == k) hit = i;
        if (!used[i]) spare = i;
      end
      r.cell_value = dflt;
      r.found      = 1'b0;
      r.dropped    = 1'b0;
      if (op == OP_READ) begin
        if (hit >= 0) begin
          r.cell_value = data[hit];
          r.found      = 1'b1;
        end
      end else if (value == dflt) begin
        if (hit >= 0) begin
          used[hit] = 1'b0;
          live--;
        end
      end else if (hit >= 0) begin
        data[hit]    = value;
        r.cell_value = value;
        r.found      = 1'b1;
      end else if (spare >= 0) begin
        used[spare]  = 1'b1;
        key[spare]   = k;
        data[spare]  = value;
        live++;
        r.cell_value = value;
        r.found      = 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
      r.entry_count = COUNT_W'(live);
      due.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (due.size() == 0) begin
        $error("result transfer with no access outstanding");
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value expected %0d actual %0d", want.cell_value, got.cell_value);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found expected %0d actual %0d", want.found, got.found);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count expected %0d actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  smd_req_if req();
  smd_rsp_if rsp();
  smd_cfg_if cfg();

  sparse_matrix_default_store uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  cell_tracker      tracker = new();
  int               cycles = 0;
  int               gap_odds = 0;
  int               stall_odds = 0;
  logic [KEY_W-1:0] keys[POOL];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sparse_matrix_default_store verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      tracker.check_reply(reply_t'{rsp.cell_value, rsp.found, rsp.entry_count, rsp.dropped});
  end

  initial begin
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COORD_BITS'($urandom_range(0, 3));
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return tracker.dflt;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_odds();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
  endfunction

  task automatic send_access(logic op, logic [COORD_BITS-1:0] row,
                             logic [COORD_BITS-1:0] col, word_t value);
    req.valid <= 1'b1;
    req.op    <= op;
    req.row   <= row;
    req.col   <= col;
    req.value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    tracker.note_access(op, row, col, value);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
  endtask

  task automatic write_default(word_t v);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    tracker.set_default(v);
  endtask

  task automatic run_phase(int n, int span, int read_pct, int erase_pct);
    logic [KEY_W-1:0] k;
    logic             op;
    word_t            v;
    for (int i = 0; i < 16; i++)
      keys[$urandom_range(4, POOL - 1)] = {pick_coord(), pick_coord()};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) k = $urandom;
      else k = keys[$urandom_range(0, span - 1)];
      op = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_WRITE;
      if (op == OP_READ) v = $urandom;
      else if ($urandom_range(0, 99) < erase_pct) v = tracker.dflt;
      else v = pick_value();
      send_access(op, k[KEY_W-1:COORD_BITS], k[COORD_BITS-1:0], v);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.op    <= OP_READ;
    req.row   <= '0;
    req.col   <= '0;
    req.value <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    foreach (keys[i]) keys[i] = {pick_coord(), pick_coord()};
    keys[0] = '0;
    keys[1] = '1;
    keys[2] = {{COORD_BITS{1'b0}}, {COORD_BITS{1'b1}}};
    keys[3] = {{COORD_BITS{1'b1}}, {COORD_BITS{1'b0}}};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    gap_odds   = 4;
    stall_odds = 4;

    send_access(OP_READ,  '0, '0, WORD_MAX);
    send_access(OP_WRITE, '0, '0, WORD_MAX);
    send_access(OP_READ,  '0, '0, '0);
    send_access(OP_WRITE, '1, '1, WORD_MIN);
    send_access(OP_WRITE, '0, '1, '0);
    send_access(OP_WRITE, '1, '0, 1);
    send_access(OP_WRITE, '0, '0, -2);
    send_access(OP_READ,  '0, '0, '1);
    send_access(OP_WRITE, '1, '0, -1);
    send_access(OP_READ,  '1, '0, '0);
    send_access(OP_WRITE, 16'h1234, 16'h5678, -1);
    send_access(OP_READ,  16'h1234, 16'h5678, '0);
    send_access(OP_READ,  '1, '1, '0);
    send_access(OP_READ,  '0, '1, '0);
    drain();

    gap_odds = pick_odds();
    stall_odds = pick_odds();
    write_default('0);
    run_phase(200, 6, 40, 20);
    drain();

    gap_odds = pick_odds();
    stall_odds = pick_odds();
    write_default(WORD_MAX);
    run_phase(250, 128, 15, 5);
    drain();

    // default now equals a value still held in the table, when one is held
    gap_odds = pick_odds();
    stall_odds = pick_odds();
    write_default(tracker.held_value());
    run_phase(200, 96, 40, 25);
    drain();

    gap_odds = pick_odds();
    stall_odds = pick_odds();
    write_default(WORD_MIN);
    run_phase(200, 40, 35, 30);
    drain();

    gap_odds = pick_odds();
    stall_odds = pick_odds();
    write_default($urandom);
    run_phase(250, 128, 20, 10);
    drain();

    gap_odds   = 0;
    stall_odds = 0;
    write_default(-1);
    run_phase(250, 70, 35, 20);
    drain();

    repeat (80) @(posedge clk);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("sparse_matrix_default_store verification clean");
    end else begin
      $display("sparse_matrix_default_store verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/smd_pkg.sv
src/smd_if.sv
src/smd_ctrl.sv
src/smd_dp.sv
src/sparse_matrix_default_store.sv
src/smd_chk.sv
sim/testbench.sv
